// File: hw/rtl/wpmh_pkg.sv
`default_nettype none
package wpmh_pkg;

  // Element and value widths
  localparam int ELEM_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int LEVEL_BITS  = 16;
  localparam int RATE_BITS   = 16;

  // Accumulator widths
  localparam int ABS_BITS = 32;
  localparam int SQ_BITS  = 47;
  localparam int CNT_BITS = 17;
  localparam int MAGSQ_BITS = 2 * WEIGHT_BITS - 1;

  // Divider remainder width and step counter width
  localparam int REM_BITS  = CNT_BITS + 1;
  localparam int STEP_BITS = $clog2(SQ_BITS);

  // Threshold width (mean in Q16.12 plus rate times deviation, clamped at zero)
  localparam int THR_BITS = 32;
  localparam int CMP_BITS = THR_BITS + 5;

  typedef enum logic [1:0] {
    FUNC_ACCUM  = 2'd0,
    FUNC_FINAL  = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FIN
  } top_state_t;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_DIV_ABS,
    FIN_DIV_SQ,
    FIN_SQUARE,
    FIN_VAR,
    FIN_ROOT,
    FIN_DONE
  } fin_state_t;

  typedef struct packed {
    logic                  done;
    logic [LEVEL_BITS-1:0] mean;
    logic [LEVEL_BITS-1:0] dev;
  } fin_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/wpmh_finalize.sv
`default_nettype none
module wpmh_finalize import wpmh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ABS_BITS-1:0] abs_sum,
  input  logic [SQ_BITS-1:0]  square_sum,
  input  logic [CNT_BITS-1:0] count,
  output fin_res_t            res
);

  fin_state_t state, state_next;

  logic [CNT_BITS-1:0]   n;
  logic [SQ_BITS-1:0]    dvd;
  logic [REM_BITS-1:0]   rem;
  logic [STEP_BITS-1:0]  step;
  logic [LEVEL_BITS-1:0] mean;
  logic [2*LEVEL_BITS-1:0] msq;
  logic [SQ_BITS-1:0]    x;
  logic [SQ_BITS-1:0]    r;
  logic [SQ_BITS-1:0]    rbit;

  logic [REM_BITS-1:0] rem_shift;
  logic                rem_ge;
  logic [REM_BITS-1:0] rem_sub;
  logic [SQ_BITS-1:0]  quot_next;
  logic                last_step;
  logic [SQ_BITS-1:0]  trial;
  logic                root_ge;
  logic [SQ_BITS-1:0]  msq_ext;

  // One restoring divide step per cycle
  assign rem_shift = {rem[REM_BITS-2:0], dvd[SQ_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, n};
  assign rem_sub   = rem_shift - {1'b0, n};
  assign quot_next = {dvd[SQ_BITS-2:0], rem_ge};
  assign last_step = step == STEP_BITS'(SQ_BITS - 1);

  // One square root digit per cycle
  assign trial   = r + rbit;
  assign root_ge = x >= trial;
  assign msq_ext = {{(SQ_BITS - 2*LEVEL_BITS){1'b0}}, msq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FIN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FIN_IDLE:    if (start) state_next = FIN_DIV_ABS;
      FIN_DIV_ABS: if (last_step) state_next = FIN_DIV_SQ;
      FIN_DIV_SQ:  if (last_step) state_next = FIN_SQUARE;
      FIN_SQUARE:  state_next = FIN_VAR;
      FIN_VAR:     state_next = FIN_ROOT;
      FIN_ROOT:    if (rbit[0]) state_next = FIN_DONE;
      FIN_DONE:    state_next = FIN_IDLE;
      default:     state_next = FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        n    <= count;
        dvd  <= {{(SQ_BITS - ABS_BITS){1'b0}}, abs_sum};
        rem  <= '0;
        step <= '0;
      end
      FIN_DIV_ABS: begin
        rem  <= rem_ge ? rem_sub : rem_shift;
        step <= step + 1'b1;
        dvd  <= quot_next;
        if (last_step) begin
          mean <= (|quot_next[SQ_BITS-1:LEVEL_BITS]) ? '1 : quot_next[LEVEL_BITS-1:0];
          dvd  <= square_sum;
          rem  <= '0;
          step <= '0;
        end
      end
      FIN_DIV_SQ: begin
        rem  <= rem_ge ? rem_sub : rem_shift;
        step <= step + 1'b1;
        dvd  <= quot_next;
      end
      FIN_SQUARE: begin
        msq <= {{LEVEL_BITS{1'b0}}, mean} * {{LEVEL_BITS{1'b0}}, mean};
      end
      FIN_VAR: begin
        x    <= (dvd > msq_ext) ? dvd - msq_ext : '0;
        r    <= '0;
        rbit <= {1'b1, {(SQ_BITS - 1){1'b0}}};
      end
      FIN_ROOT: begin
        if (root_ge) begin
          x <= x - trial;
          r <= (r >> 1) + rbit;
        end else begin
          r <= r >> 1;
        end
        rbit <= rbit >> 2;
      end
      default: begin
      end
    endcase
  end

  assign res.done = state == FIN_DONE;
  assign res.mean = mean;
  assign res.dev  = (|r[SQ_BITS-1:LEVEL_BITS]) ? '1 : r[LEVEL_BITS-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/weight_pruning_mask_hysteresis_top.sv
`default_nettype none
// Channel   Handshake               Payload
// item      start / busy            func, element_index, weight_value
// result    done (one-cycle strobe) masked_weight, mask_bit, mean_level,
//                                   deviation_level, status
// config    cfg_valid / cfg_ready   threshold_rate
//
// Accumulate, update and read items read the mask memory synchronously at the
// offered index on accept, then modify, write back and register the result.
// A finalize item with a nonzero count runs two 47-step restoring divides,
// a square, a subtract and a 24-step square root before its result.
// After reset the mask memory is swept to ones, one entry a cycle, over all
// 65536 entries with busy high; configuration writes are taken during the sweep.
// Busy also stays high after a configuration write or a finalize, while the
// registered threshold catches up. The result side never stalls.
module weight_pruning_mask_hysteresis_top import wpmh_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [ELEM_BITS-1:0]          element_index,
  input  logic signed [WEIGHT_BITS-1:0] weight_value,
  output logic                          done,
  output logic signed [WEIGHT_BITS-1:0] masked_weight,
  output logic                          mask_bit,
  output logic [LEVEL_BITS-1:0]         mean_level,
  output logic [LEVEL_BITS-1:0]         deviation_level,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic signed [RATE_BITS-1:0]   threshold_rate
);

  localparam int MAX_ELEMS = 2 ** ELEM_BITS;

  top_state_t state, state_next;

  // Mask memory, one bit per element, 1 means kept
  logic mask_mem [0:MAX_ELEMS-1];
  logic mask_rd;
  logic                 mem_we;
  logic [ELEM_BITS-1:0] mem_waddr;
  logic                 mem_wdata;
  logic [ELEM_BITS-1:0] clear_idx;

  // Configuration and statistics
  logic signed [RATE_BITS-1:0] rate;
  logic [ABS_BITS-1:0]   abs_sum;
  logic [SQ_BITS-1:0]    square_sum;
  logic [CNT_BITS-1:0]   nonzero_count;
  logic [LEVEL_BITS-1:0] mean_reg;
  logic [LEVEL_BITS-1:0] deviation_reg;
  logic [1:0]            settle;

  // Threshold pipeline
  logic signed [RATE_BITS+LEVEL_BITS:0]   prod;
  logic signed [RATE_BITS+LEVEL_BITS+1:0] tsum;
  logic [THR_BITS-1:0]                    thr;

  // Latched item
  func_t                         func_q;
  logic [ELEM_BITS-1:0]          idx_q;
  logic signed [WEIGHT_BITS-1:0] w_q;
  logic [WEIGHT_BITS-1:0]        mag_q;
  logic [MAGSQ_BITS-1:0]         magsq_q;
  logic                          bit_hold;

  logic [WEIGHT_BITS-1:0] mag_in;
  logic                   accept;
  logic                   cfg_write;

  // Exec-cycle datapath
  logic [ABS_BITS:0]      abs_add;
  logic [SQ_BITS:0]       sq_add;
  logic [WEIGHT_BITS+3:0] mag10;
  logic [CMP_BITS-1:0]    lhs;
  logic [CMP_BITS-1:0]    t9;
  logic [CMP_BITS-1:0]    t11;
  logic                   new_bit;

  // Control out of the state machine
  logic                          acc_en;
  logic                          fin_start;
  logic                          res_load;
  logic signed [WEIGHT_BITS-1:0] res_masked;
  logic                          res_bit;
  logic                          res_status;

  fin_res_t fin_res;

  wpmh_finalize u_finalize (
    .clk        (clk),
    .rst        (rst),
    .start      (fin_start),
    .abs_sum    (abs_sum),
    .square_sum (square_sum),
    .count      (nonzero_count),
    .res        (fin_res)
  );

  assign busy      = (state != S_IDLE) || (settle != 2'd0);
  assign accept    = start && !busy;
  assign cfg_ready = (state == S_IDLE || state == S_CLEAR) && !start;
  assign cfg_write = cfg_valid && cfg_ready;

  assign mag_in = weight_value[WEIGHT_BITS-1] ? WEIGHT_BITS'(-weight_value)
                                              : WEIGHT_BITS'(weight_value);

  // Saturating accumulators
  assign abs_add = {1'b0, abs_sum} + {{(ABS_BITS + 1 - WEIGHT_BITS){1'b0}}, mag_q};
  assign sq_add  = {1'b0, square_sum} + {{(SQ_BITS + 1 - MAGSQ_BITS){1'b0}}, magsq_q};

  // Hysteresis compare in Q25.12: 10|w| against 9T and 11T
  assign mag10 = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0};
  assign lhs   = {{(CMP_BITS - WEIGHT_BITS - 16){1'b0}}, mag10, 12'd0};
  assign t9    = {2'b00, thr, 3'b000} + {5'd0, thr};
  assign t11   = {2'b00, thr, 3'b000} + {4'd0, thr, 1'b0} + {5'd0, thr};

  always_comb begin
    new_bit = mask_rd;
    if (mask_rd && lhs <= t9) begin
      new_bit = 1'b0;
    end else if (!mask_rd && lhs > t11) begin
      new_bit = 1'b1;
    end
  end

  function automatic logic [THR_BITS-1:0] thr_trunc(
    input logic signed [RATE_BITS+LEVEL_BITS+1:0] v
  );
    thr_trunc = v[THR_BITS-1:0];
  endfunction

  // Threshold: register the product, then add mean and clamp at zero
  assign tsum = $signed({{(RATE_BITS - 10){1'b0}}, mean_reg, 12'd0})
              + $signed({prod[RATE_BITS+LEVEL_BITS], prod});

  always_ff @(posedge clk) begin
    prod <= $signed({{(LEVEL_BITS + 1){rate[RATE_BITS-1]}}, rate})
          * $signed({{RATE_BITS{1'b0}}, 1'b0, deviation_reg});
    thr  <= tsum[RATE_BITS+LEVEL_BITS+1] ? '0 : thr_trunc(tsum);
  end

  // Mask memory: read every cycle at the offered index, one write port
  always_ff @(posedge clk) begin
    mask_rd <= mask_mem[element_index];
    if (mem_we) begin
      mask_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory write and result selection
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = new_bit;
    acc_en     = 1'b0;
    fin_start  = 1'b0;
    res_load   = 1'b0;
    res_masked = '0;
    res_bit    = mask_rd;
    res_status = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_idx;
        mem_wdata = 1'b1;
        if (clear_idx == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (func_q)
          FUNC_ACCUM: begin
            acc_en     = 1'b1;
            res_load   = 1'b1;
            state_next = S_IDLE;
          end
          FUNC_FINAL: begin
            if (nonzero_count == '0) begin
              res_load   = 1'b1;
              res_status = 1'b1;
              state_next = S_IDLE;
            end else begin
              fin_start  = 1'b1;
              state_next = S_FIN;
            end
          end
          FUNC_UPDATE: begin
            mem_we     = 1'b1;
            res_load   = 1'b1;
            res_bit    = new_bit;
            res_masked = new_bit ? w_q : '0;
            state_next = S_IDLE;
          end
          FUNC_READ: begin
            res_load   = 1'b1;
            res_masked = mask_rd ? w_q : '0;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FIN: begin
        res_bit = bit_hold;
        if (fin_res.done) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate          <= '0;
      abs_sum       <= '0;
      square_sum    <= '0;
      nonzero_count <= '0;
      mean_reg      <= '0;
      deviation_reg <= '0;
      settle        <= 2'd0;
      clear_idx     <= '0;
      done          <= 1'b0;
    end else begin
      done <= res_load;
      if (state == S_CLEAR) begin
        clear_idx <= clear_idx + 1'b1;
      end
      // Hold off items until the threshold pipeline reflects new settings
      if (cfg_write) begin
        rate   <= threshold_rate;
        settle <= 2'd2;
      end else if (state == S_FIN && fin_res.done) begin
        settle <= 2'd2;
      end else if (settle != 2'd0) begin
        settle <= settle - 1'b1;
      end
      if (acc_en) begin
        abs_sum    <= abs_add[ABS_BITS] ? '1 : abs_add[ABS_BITS-1:0];
        square_sum <= sq_add[SQ_BITS] ? '1 : sq_add[SQ_BITS-1:0];
        if (w_q != '0 && nonzero_count != '1) begin
          nonzero_count <= nonzero_count + 1'b1;
        end
      end
      if (state == S_FIN && fin_res.done) begin
        mean_reg      <= fin_res.mean;
        deviation_reg <= fin_res.dev;
      end
    end
  end

  // Payload registers: latch the beat on accept, hold the result for its strobe
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func_t'(func);
      idx_q   <= element_index;
      w_q     <= weight_value;
      mag_q   <= mag_in;
      magsq_q <= {{(MAGSQ_BITS - WEIGHT_BITS){1'b0}}, mag_in}
               * {{(MAGSQ_BITS - WEIGHT_BITS){1'b0}}, mag_in};
    end
    if (state == S_EXEC) begin
      bit_hold <= mask_rd;
    end
    if (res_load) begin
      masked_weight <= res_masked;
      mask_bit      <= res_bit;
      status        <= res_status;
    end
  end

  // Levels change only on the edge that ends a finalize, so they are current
  // on every strobe
  assign mean_level      = mean_reg;
  assign deviation_level = deviation_reg;

endmodule
`default_nettype wire
